### sv/svib_pkg.sv
// Package for the shadow volume index builder: face capacity, request kinds,
// triangle roles, register indexes and the triangle record type.
// Depends on nothing.
`default_nettype none

package svib_pkg;

   localparam int MAX_FACES = 4096;
   localparam int FACE_AW   = $clog2(MAX_FACES);
   localparam int CNT_W     = $clog2(MAX_FACES + 1);
   localparam int FACE_IW   = 12;
   localparam int CMP_W     = (CNT_W > FACE_IW) ? CNT_W : FACE_IW;

   localparam logic [1:0] KIND_FACE    = 2'd0;
   localparam logic [1:0] KIND_EDGE    = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   localparam logic [1:0] ROLE_NEAR = 2'd0;
   localparam logic [1:0] ROLE_FAR  = 2'd1;
   localparam logic [1:0] ROLE_SIDE = 2'd2;

   localparam logic [2:0] CSR_LIGHT_X      = 3'd0;
   localparam logic [2:0] CSR_LIGHT_Y      = 3'd1;
   localparam logic [2:0] CSR_LIGHT_Z      = 3'd2;
   localparam logic [2:0] CSR_LIGHT_W      = 3'd3;
   localparam logic [2:0] CSR_VERTEX_COUNT = 3'd4;
   localparam logic [2:0] CSR_WIDE_INDEX   = 3'd5;

   typedef struct packed {
      logic [31:0] idx0;
      logic [31:0] idx1;
      logic [31:0] idx2;
      logic [1:0]  role;
   } tri_type;

   function automatic logic [31:0] index_wrap(input logic [31:0] v, input logic wide);
      index_wrap = wide ? v : {16'd0, v[15:0]};
   endfunction

endpackage

`default_nettype wire

### sv/shadow_volume_index_builder_top.sv
// Shadow volume index builder: face light test, facing bit store, cap and
// silhouette side triangle output. Depends on svib_pkg.
//
// Flow: a request is registered in stage 1, then stage 2, where the four light
// products sit; its triangle pair is loaded into stage 3 and the second triangle
// follows in the cycle after the first is taken. A request that yields triangles
// holds stage 3 for both (one result port); one that yields none does not wait.
// Reset: clears pipeline valids, the face counter and config to reset values;
// the facing bit memory is not cleared.
`default_nettype none

module shadow_volume_index_builder_top
   import svib_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_kind,
   input  wire logic signed [31:0] req_plane_a,
   input  wire logic signed [31:0] req_plane_b,
   input  wire logic signed [31:0] req_plane_c,
   input  wire logic signed [31:0] req_plane_d,
   input  wire logic [31:0]        req_corner_0,
   input  wire logic [31:0]        req_corner_1,
   input  wire logic [31:0]        req_corner_2,
   input  wire logic signed [12:0] req_left_face,
   input  wire logic signed [12:0] req_right_face,
   input  wire logic [31:0]        req_edge_start,
   input  wire logic [31:0]        req_edge_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [31:0]             rsp_tri_index_0,
   output logic [31:0]             rsp_tri_index_1,
   output logic [31:0]             rsp_tri_index_2,
   output logic [1:0]              rsp_tri_role,
   output logic                    rsp_last_of_run
);

   // configuration
   logic signed [31:0] light_x_ff, light_y_ff, light_z_ff, light_w_ff;
   logic [31:0]        vertex_count_ff;
   logic               wide_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff      <= '0;
         light_y_ff      <= '0;
         light_z_ff      <= '0;
         light_w_ff      <= '0;
         vertex_count_ff <= '0;
         wide_index_ff   <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LIGHT_X:      light_x_ff      <= csr_wdata;
            CSR_LIGHT_Y:      light_y_ff      <= csr_wdata;
            CSR_LIGHT_Z:      light_z_ff      <= csr_wdata;
            CSR_LIGHT_W:      light_w_ff      <= csr_wdata;
            CSR_VERTEX_COUNT: vertex_count_ff <= csr_wdata;
            CSR_WIDE_INDEX:   wide_index_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage 1: request register
   logic               s1_valid_ff;
   logic [1:0]         s1_kind_ff;
   logic signed [31:0] s1_pa_ff, s1_pb_ff, s1_pc_ff, s1_pd_ff;
   logic [31:0]        s1_c0_ff, s1_c1_ff, s1_c2_ff;
   logic signed [12:0] s1_lf_ff, s1_rf_ff;
   logic [31:0]        s1_es_ff, s1_ee_ff;

   // stage 2: products, indexes, facing bits
   logic               s2_valid_ff;
   logic [1:0]         s2_kind_ff;
   logic signed [63:0] s2_p0_ff, s2_p1_ff, s2_p2_ff, s2_p3_ff;
   logic [31:0]        s2_v0_ff, s2_v1_ff, s2_v2_ff;
   logic [31:0]        s2_w0_ff, s2_w1_ff, s2_w2_ff;
   logic [CNT_W-1:0]   s2_slot_ff;
   logic               s2_ok_l_ff, s2_ok_r_ff;
   logic               s2_rd_l_ff, s2_rd_r_ff;
   logic               s2_fwd_l_ff, s2_fwd_r_ff, s2_fwd_val_ff;

   // stage 3: triangle pair
   tri_type            s3_tri_a_ff, s3_tri_b_ff;
   logic [1:0]         s3_cnt_ff;

   logic [CNT_W-1:0]   faces_loaded_ff;
   logic               facing_mem [MAX_FACES];

   logic               s1_adv, s2_adv, s3_free, s2_has;
   logic signed [65:0] s2_sum;
   logic               s2_lit, s2_bit_l, s2_bit_r;
   logic               mem_we;
   logic [FACE_AW-1:0] mem_waddr, laddr, raddr;
   logic               ok_l_in, ok_r_in;
   logic [31:0]        v0_in, v1_in, v2_in;
   tri_type            tri_a_in, tri_b_in;

   assign s3_free   = (s3_cnt_ff == 2'd0) || ((s3_cnt_ff == 2'd1) && rsp_ready);
   assign s2_adv    = s2_valid_ff && (s3_free || !s2_has);
   assign s1_adv    = s1_valid_ff && (!s2_valid_ff || s2_adv);
   assign req_ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         s1_kind_ff <= req_kind;
         s1_pa_ff   <= req_plane_a;
         s1_pb_ff   <= req_plane_b;
         s1_pc_ff   <= req_plane_c;
         s1_pd_ff   <= req_plane_d;
         s1_c0_ff   <= req_corner_0;
         s1_c1_ff   <= req_corner_1;
         s1_c2_ff   <= req_corner_2;
         s1_lf_ff   <= req_left_face;
         s1_rf_ff   <= req_right_face;
         s1_es_ff   <= req_edge_start;
         s1_ee_ff   <= req_edge_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         faces_loaded_ff <= '0;
      end else if (s1_adv) begin
         if (s1_kind_ff == KIND_RESTART) begin
            faces_loaded_ff <= '0;
         end else if ((s1_kind_ff == KIND_FACE) && (faces_loaded_ff != CNT_W'(MAX_FACES))) begin
            faces_loaded_ff <= faces_loaded_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      laddr   = FACE_AW'(s1_lf_ff[FACE_IW-1:0]);
      raddr   = FACE_AW'(s1_rf_ff[FACE_IW-1:0]);
      ok_l_in = !s1_lf_ff[12] && (CMP_W'(s1_lf_ff[FACE_IW-1:0]) < CMP_W'(faces_loaded_ff));
      ok_r_in = !s1_rf_ff[12] && (CMP_W'(s1_rf_ff[FACE_IW-1:0]) < CMP_W'(faces_loaded_ff));
      if (s1_kind_ff == KIND_FACE) begin
         v0_in = s1_c0_ff;
         v1_in = s1_c1_ff;
         v2_in = s1_c2_ff;
      end else begin
         v0_in = s1_es_ff;
         v1_in = s1_ee_ff;
         v2_in = s1_ee_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (!s2_valid_ff || s2_adv) begin
         s2_valid_ff <= s1_adv;
      end
      if (s1_adv) begin
         s2_kind_ff    <= s1_kind_ff;
         s2_p0_ff      <= 64'(s1_pa_ff) * 64'(light_x_ff);
         s2_p1_ff      <= 64'(s1_pb_ff) * 64'(light_y_ff);
         s2_p2_ff      <= 64'(s1_pc_ff) * 64'(light_z_ff);
         s2_p3_ff      <= 64'(s1_pd_ff) * 64'(light_w_ff);
         s2_v0_ff      <= index_wrap(v0_in, wide_index_ff);
         s2_v1_ff      <= index_wrap(v1_in, wide_index_ff);
         s2_v2_ff      <= index_wrap(v2_in, wide_index_ff);
         s2_w0_ff      <= index_wrap(v0_in + vertex_count_ff, wide_index_ff);
         s2_w1_ff      <= index_wrap(v1_in + vertex_count_ff, wide_index_ff);
         s2_w2_ff      <= index_wrap(v2_in + vertex_count_ff, wide_index_ff);
         s2_slot_ff    <= faces_loaded_ff;
         s2_ok_l_ff    <= ok_l_in;
         s2_ok_r_ff    <= ok_r_in;
         // bypass a face bit written on this same edge
         s2_fwd_l_ff   <= mem_we && (mem_waddr == laddr);
         s2_fwd_r_ff   <= mem_we && (mem_waddr == raddr);
         s2_fwd_val_ff <= s2_lit;
      end
   end

   assign mem_we    = s2_adv && (s2_kind_ff == KIND_FACE) && (s2_slot_ff != CNT_W'(MAX_FACES));
   assign mem_waddr = s2_slot_ff[FACE_AW-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         facing_mem[mem_waddr] <= s2_lit;
      end
      if (s1_adv) begin
         s2_rd_l_ff <= facing_mem[laddr];
         s2_rd_r_ff <= facing_mem[raddr];
      end
   end

   always_comb begin
      s2_sum   = 66'(s2_p0_ff) + 66'(s2_p1_ff) + 66'(s2_p2_ff) + 66'(s2_p3_ff);
      s2_lit   = s2_sum[65] || (s2_sum == '0);
      s2_bit_l = s2_ok_l_ff && (s2_fwd_l_ff ? s2_fwd_val_ff : s2_rd_l_ff);
      s2_bit_r = s2_ok_r_ff && (s2_fwd_r_ff ? s2_fwd_val_ff : s2_rd_r_ff);
      case (s2_kind_ff)
         KIND_FACE: s2_has = s2_lit;
         KIND_EDGE: s2_has = s2_bit_l != s2_bit_r;
         default:   s2_has = 1'b0;
      endcase
      if (s2_kind_ff == KIND_FACE) begin
         tri_a_in = '{idx0: s2_v0_ff, idx1: s2_v1_ff, idx2: s2_v2_ff, role: ROLE_NEAR};
         tri_b_in = '{idx0: s2_w0_ff, idx1: s2_w2_ff, idx2: s2_w1_ff, role: ROLE_FAR};
      end else if (s2_bit_l) begin
         tri_a_in = '{idx0: s2_v0_ff, idx1: s2_v1_ff, idx2: s2_w1_ff, role: ROLE_SIDE};
         tri_b_in = '{idx0: s2_v0_ff, idx1: s2_w1_ff, idx2: s2_w0_ff, role: ROLE_SIDE};
      end else begin
         tri_a_in = '{idx0: s2_v0_ff, idx1: s2_w0_ff, idx2: s2_w1_ff, role: ROLE_SIDE};
         tri_b_in = '{idx0: s2_v0_ff, idx1: s2_w1_ff, idx2: s2_v1_ff, role: ROLE_SIDE};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_cnt_ff <= 2'd0;
      end else if (s2_adv && s2_has) begin
         s3_cnt_ff <= 2'd2;
      end else if (rsp_valid && rsp_ready) begin
         s3_cnt_ff <= s3_cnt_ff - 2'd1;
      end
      if (s2_adv && s2_has) begin
         s3_tri_a_ff <= tri_a_in;
         s3_tri_b_ff <= tri_b_in;
      end
   end

   always_comb begin
      rsp_valid       = s3_cnt_ff != 2'd0;
      rsp_last_of_run = s3_cnt_ff == 2'd1;
      if (s3_cnt_ff == 2'd2) begin
         rsp_tri_index_0 = s3_tri_a_ff.idx0;
         rsp_tri_index_1 = s3_tri_a_ff.idx1;
         rsp_tri_index_2 = s3_tri_a_ff.idx2;
         rsp_tri_role    = s3_tri_a_ff.role;
      end else begin
         rsp_tri_index_0 = s3_tri_b_ff.idx0;
         rsp_tri_index_1 = s3_tri_b_ff.idx1;
         rsp_tri_index_2 = s3_tri_b_ff.idx2;
         rsp_tri_role    = s3_tri_b_ff.role;
      end
   end

   a_pair_loaded: assert property (@(posedge clock) disable iff (reset)
      s2_adv && s2_has |=> rsp_valid && !rsp_last_of_run)
      else $error("triangle pair not loaded");

   a_pair_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_run |=> rsp_valid && rsp_last_of_run)
      else $error("second triangle of pair missing");

   a_face_cap: assert property (@(posedge clock) disable iff (reset)
      faces_loaded_ff <= CNT_W'(MAX_FACES))
      else $error("face counter past capacity");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_adv |=> s2_valid_ff && $stable(s2_slot_ff))
      else $error("stalled stage 2 lost its item");

endmodule

`default_nettype wire
